// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the console block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tccs_pkg.sv
// Package with the types and constants of the text console block.
`default_nettype none
package tccs_pkg;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7F;

   localparam logic [15:0] BLANK_CELL = 16'h0F20;
   localparam int          TAB_STEP   = 8;
   localparam int          COL_W      = 7;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_READ,
      S_COPY,
      S_FILL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic take;
      logic exec;
      logic copy_step;
      logic fill_step;
      logic read_capture;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       scroll;
      logic       copy_last;
      logic       fill_last;
      logic       rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: hw/rtl/text_console_cursor_scroll.sv
// Top level of the text console with cursor, scroll, clear and cell read.
//
//   Channel  Direction  Handshake                Contents
//   req      in         req_tvalid / req_tready  kind in tuser, put/read fields in tdata
//   rsp      out        rsp_tvalid / rsp_tready  cursor and cell word in tdata
//
// A put that does not scroll, and any item of the unused kind, goes from execute to response.
// A read also passes a capture state, since the screen memory has a registered read port.
// Clear blanks every cell; a scroll copies rows up and blanks the bottom row, one write per cycle at most.
// After reset the memory is blanked before the first transaction is taken.
// A result waits in the output register; while it stalls, the next result waits in the
// controller and holds off the input.
`default_nettype none
module text_console_cursor_scroll
   import tccs_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // char_code, back_colour, fore_colour, cell_index
   input  wire logic [1:0]  req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // cursor_position, cursor_column, cursor_row, cell_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tccs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tccs_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_kind        (req_tuser),
      .in_char_code   (req_tdata[7:0]),
      .in_back_colour (req_tdata[11:8]),
      .in_fore_colour (req_tdata[15:12]),
      .in_cell_index  (req_tdata[26:16]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: hw/rtl/tccs_ctrl.sv
// Controller state machine that sequences items, scroll copies and blank fills.
`default_nettype none
module tccs_ctrl
   import tccs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            case (status.kind)
               KIND_PUT:   state_in = status.scroll ? S_COPY : S_RESP;
               KIND_CLEAR: state_in = S_FILL;
               KIND_READ:  state_in = S_READ;
               default:    state_in = S_RESP;
            endcase
         end
         S_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = S_RESP;
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_last) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               req_tready   = 1'b1;
               if (req_tvalid) begin
                  cmd.take = 1'b1;
                  state_in = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/tccs_dp.sv
// Datapath with the screen memory, cursor registers, sweep counter and result register.
`default_nettype none
module tccs_dp
   import tccs_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status,
   input  wire logic [1:0]    in_kind,
   input  wire logic [7:0]    in_char_code,
   input  wire logic [3:0]    in_back_colour,
   input  wire logic [3:0]    in_fore_colour,
   input  wire logic [10:0]   in_cell_index,
   input  wire logic          rsp_tready,
   output logic               rsp_tvalid,
   output logic [39:0]        rsp_tdata
);

   localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(SCREEN_HEIGHT);

   logic [15:0] mem [CELLS];
   logic [15:0] rdata_ff;

   logic [1:0]       kind_ff;
   logic [7:0]       code_ff;
   logic [3:0]       back_ff;
   logic [3:0]       fore_ff;
   logic [10:0]      index_ff;
   logic [COL_W-1:0] col_ff;
   logic [RW-1:0]    row_ff;
   logic [AW-1:0]    cnt_ff;
   logic [15:0]      data_ff;
   logic             out_valid_ff;
   logic [38:0]      out_data_ff;

   logic [7:0]    col_ext;
   logic [7:0]    nc;
   logic [RW:0]   nr;
   logic          put_wr;
   logic          scroll;
   logic [31:0]   cur_pos;
   logic [31:0]   row_ext;
   logic [31:0]   read_sum;
   logic          idx_ok;
   logic          we;
   logic [AW-1:0] wa;
   logic [AW-1:0] ra;
   logic [15:0]   wd;
   logic          copy_last;
   logic          fill_last;

   always_comb begin
      col_ext = {1'b0, col_ff};
      nc      = col_ext;
      nr      = {1'b0, row_ff};
      put_wr  = 1'b0;
      case (code_ff) inside
         CH_BS: begin
            if (col_ext != 8'd0) begin
               nc = col_ext - 8'd1;
            end
         end
         CH_TAB: nc = (col_ext + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
         CH_CR:  nc = 8'd0;
         CH_LF: begin
            nc = 8'd0;
            nr = nr + 1'b1;
         end
         [CH_PRINT_LO:CH_PRINT_HI]: begin
            put_wr = 1'b1;
            nc     = col_ext + 8'd1;
         end
         default: ;
      endcase
      if (nc >= 8'(SCREEN_WIDTH)) begin
         nc = 8'd0;
         nr = nr + 1'b1;
      end
      scroll = (nr >= (RW + 1)'(SCREEN_HEIGHT));
   end

   assign row_ext   = 32'(row_ff);
   assign cur_pos   = row_ext * SCREEN_WIDTH + 32'(col_ff);
   assign read_sum  = 32'(cnt_ff) + SCREEN_WIDTH;
   assign idx_ok    = (32'(index_ff) < CELLS);
   assign copy_last = (cnt_ff == AW'(CELLS - SCREEN_WIDTH));
   assign fill_last = (cnt_ff == AW'(CELLS - 1));

   always_comb begin
      we = 1'b0;
      wa = cur_pos[AW-1:0];
      wd = {back_ff, fore_ff, code_ff};
      if (cmd.exec && (kind_ff == KIND_PUT) && put_wr) begin
         we = 1'b1;
      end else if (cmd.copy_step && (cnt_ff != '0)) begin
         we = 1'b1;
         wa = cnt_ff - 1'b1;
         wd = rdata_ff;
      end else if (cmd.fill_step) begin
         we = 1'b1;
         wa = cnt_ff;
         wd = BLANK_CELL;
      end
      if (cmd.copy_step) begin
         ra = read_sum[AW-1:0];
      end else begin
         ra = AW'(32'(index_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff  <= in_kind;
         code_ff  <= in_char_code;
         back_ff  <= in_back_colour;
         fore_ff  <= in_fore_colour;
         index_ff <= in_cell_index;
         data_ff  <= '0;
      end else if (cmd.read_capture) begin
         data_ff <= idx_ok ? rdata_ff : 16'd0;
      end
      if (cmd.load_rsp) begin
         out_data_ff <= {data_ff, row_ext[4:0], col_ff, cur_pos[10:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            cnt_ff <= '0;
            if (kind_ff == KIND_PUT) begin
               col_ff <= nc[COL_W-1:0];
               row_ff <= scroll ? RW'(SCREEN_HEIGHT - 1) : nr[RW-1:0];
            end else if (kind_ff == KIND_CLEAR) begin
               col_ff <= '0;
               row_ff <= '0;
            end
         end else if ((cmd.copy_step && !copy_last) || (cmd.fill_step && !fill_last)) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.load_rsp) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.kind      = kind_ff;
   assign status.scroll    = scroll;
   assign status.copy_last = copy_last;
   assign status.fill_last = fill_last;
   assign status.rsp_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

endmodule
`default_nettype wire

// File: hw/rtl/tccs_checker.sv
// Port-level checker for the text console and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module tccs_checker #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   logic [31:0] col_val;
   logic [31:0] row_val;
   logic [31:0] pos_calc;

   assign col_val  = 32'(rsp_tdata[17:11]);
   assign row_val  = 32'(rsp_tdata[22:18]);
   assign pos_calc = row_val * SCREEN_WIDTH + col_val;

   `CHK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "Stalled result changed")
   `CHK_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "Transaction taken while busy")
   `CHK_SAME(a_cursor_range, rsp_tvalid, (col_val < SCREEN_WIDTH) && (row_val < SCREEN_HEIGHT), "Cursor out of screen")
   `CHK_SAME(a_pos_match, rsp_tvalid, (SCREEN_HEIGHT > 32) || (rsp_tdata[10:0] == pos_calc[10:0]), "Cursor position mismatch")

endmodule

bind text_console_cursor_scroll tccs_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tccs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// File: test/text_console_cursor_scroll_checker.sv
// Checker that predicts the console's cursor and cell reports and compares each transaction.
module text_console_cursor_scroll_checker
   import tccs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   output int               failures,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH  = 80;
   localparam int HEIGHT = 25;
   localparam int CELLS  = WIDTH * HEIGHT;

   typedef struct packed {
      logic        pad;
      logic [15:0] cell_data;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic [10:0] cursor_position;
   } console_report_type;

   logic [15:0]        screen [0:CELLS-1];
   int                 cur_col;
   int                 cur_row;
   int                 mismatch_count = 0;
   console_report_type report_q[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic apply_item(input logic [1:0] kind, input logic [7:0] code,
                             input logic [3:0] back, input logic [3:0] fore,
                             input logic [10:0] index, output console_report_type rep);
      logic [15:0] data;
      data = '0;
      case (kind)
         KIND_PUT: begin
            if (code == CH_BS) begin
               if (cur_col > 0) cur_col--;
            end else if (code == CH_TAB) begin
               cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
            end else if (code == CH_CR) begin
               cur_col = 0;
            end else if (code == CH_LF) begin
               cur_col = 0;
               cur_row++;
            end else if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
               screen[cur_row * WIDTH + cur_col] = {back, fore, code};
               cur_col++;
            end
            if (cur_col >= WIDTH) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= HEIGHT) begin
               for (int i = 0; i + WIDTH < CELLS; i++) screen[i] = screen[i + WIDTH];
               for (int i = CELLS - WIDTH; i < CELLS; i++) screen[i] = BLANK_CELL;
               cur_row = HEIGHT - 1;
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
            cur_col = 0;
            cur_row = 0;
         end
         KIND_READ: begin
            if (index < CELLS) data = screen[index];
         end
         default: begin
         end
      endcase
      rep.pad             = 1'b0;
      rep.cell_data       = data;
      rep.cursor_row      = 5'(cur_row);
      rep.cursor_column   = 7'(cur_col);
      rep.cursor_position = 11'(cur_row * WIDTH + cur_col);
   endtask

   always @(posedge clock) begin
      console_report_type seen;
      console_report_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
         cur_col = 0;
         cur_row = 0;
         report_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (report_q.size() == 0) begin
               $error("Unexpected response transaction: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = report_q.pop_front();
               if (seen.cursor_position !== want.cursor_position) begin
                  $error("cursor_position: expected %0d, actual %0d",
                         want.cursor_position, seen.cursor_position);
                  mismatch_count++;
               end
               if (seen.cursor_column !== want.cursor_column) begin
                  $error("cursor_column: expected %0d, actual %0d",
                         want.cursor_column, seen.cursor_column);
                  mismatch_count++;
               end
               if (seen.cursor_row !== want.cursor_row) begin
                  $error("cursor_row: expected %0d, actual %0d",
                         want.cursor_row, seen.cursor_row);
                  mismatch_count++;
               end
               if (seen.cell_data !== want.cell_data) begin
                  $error("cell_data: expected %h, actual %h",
                         want.cell_data, seen.cell_data);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_item(req_tuser, req_tdata[7:0], req_tdata[11:8], req_tdata[15:12],
                       req_tdata[26:16], want);
            report_q.push_back(want);
         end
      end
      failures <= mismatch_count;
      pending  <= report_q.size();
   end

endmodule

// File: test/text_console_cursor_scroll_tb.sv
// Testbench top that drives console transactions with random idling and gives the verdict.
module text_console_cursor_scroll_tb;
   import tccs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_SPARE  = 2'd3;
   localparam int         RANDOM_ITEMS = 1150;
   localparam int         CYCLE_LIMIT  = 10_000_000;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         HOLD_AFTER   = 60;
   localparam int         HOLD_CYCLES  = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   int          failures;
   int          pending;
   int          cycles     = 0;
   int          req_calm   = 0;
   int          rsp_calm   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_cursor_scroll i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   text_console_cursor_scroll_checker i_report_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                            input logic [3:0] back, input logic [3:0] fore,
                            input logic [10:0] index);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, index, fore, back, code};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [10:0] pick_read_index();
      if ($urandom_range(0, 2) == 0) return 11'($urandom_range(0, 2047));
      return 11'($urandom_range(0, 24) * 80 + $urandom_range(0, 19));
   endfunction

   // Receiver: random stalls, plus one long hold-off that backs up the block.
   initial begin
      int taken;
      int gap;
      taken = 0;
      wait (!reset);
      forever begin
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken == HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap(rsp_calm);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int          useful;
      int          line_len;
      int          r;
      logic [7:0]  code;
      logic [1:0]  kind;
      logic [10:0] index;
      logic        ignored;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(KIND_READ, 8'h5A, 4'h3, 4'hC, 11'd0);
      send_item(KIND_PUT, CH_PRINT_LO, 4'h0, 4'h0, 11'h7FF);
      send_item(KIND_PUT, CH_PRINT_HI, 4'hF, 4'hF, 11'h000);
      send_item(KIND_PUT, 8'h41, 4'hA, 4'h5, 11'h555);
      send_item(KIND_READ, 8'hFF, 4'hF, 4'hF, 11'd0);
      send_item(KIND_READ, 8'h00, 4'h0, 4'h0, 11'd1);
      send_item(KIND_READ, 8'hA5, 4'h5, 4'hA, 11'd2);
      send_item(KIND_PUT, CH_BS, 4'h1, 4'h2, 11'h2AA);
      send_item(KIND_PUT, CH_CR, 4'h3, 4'h4, 11'h0F0);
      send_item(KIND_PUT, CH_BS, 4'h5, 4'h6, 11'h70F);
      send_item(KIND_PUT, CH_TAB, 4'h7, 4'h8, 11'h123);
      send_item(KIND_PUT, 8'h7E, 4'h5, 4'hA, 11'h456);
      send_item(KIND_PUT, CH_TAB, 4'h9, 4'hB, 11'h789);
      send_item(KIND_PUT, 8'h00, 4'hC, 4'hD, 11'h001);
      send_item(KIND_PUT, 8'h1F, 4'hE, 4'h1, 11'h3FF);
      send_item(KIND_PUT, 8'h80, 4'h2, 4'h3, 11'h400);
      send_item(KIND_PUT, 8'hFF, 4'h4, 4'h5, 11'h7FE);
      send_item(KIND_PUT, CH_LF, 4'h6, 4'h7, 11'h0AA);
      send_item(KIND_READ, 8'h33, 4'h8, 4'h9, 11'd8);
      send_item(KIND_READ, 8'hCC, 4'hA, 4'hB, 11'd1999);
      send_item(KIND_READ, 8'h66, 4'hC, 4'hD, 11'd2000);
      send_item(KIND_READ, 8'h99, 4'hE, 4'hF, 11'd2047);
      send_item(KIND_SPARE, 8'h41, 4'hF, 4'h0, 11'd5);
      send_item(KIND_CLEAR, 8'h7F, 4'h0, 4'hF, 11'd1000);
      send_item(KIND_READ, 8'h12, 4'h3, 4'h4, 11'd0);

      // Random text arrives as lines: printable runs with control codes and reads mixed in.
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100)
                                               : $urandom_range(0, 20);
         for (int k = 0; k <= line_len && useful < RANDOM_ITEMS; k++) begin
            kind    = KIND_PUT;
            ignored = 1'b0;
            index   = 11'($urandom_range(0, 2047));
            code    = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
            r       = $urandom_range(0, 999);
            if (k == line_len) begin
               r = $urandom_range(0, 99);
               if (r < 75) code = CH_LF;
               else if (r < 85) code = CH_CR;
            end else if (r < 680) begin
            end else if (r < 740) begin
               code = CH_TAB;
            end else if (r < 800) begin
               code = CH_BS;
            end else if (r < 830) begin
               code = CH_CR;
            end else if (r < 880) begin
               ignored = 1'b1;
               do code = 8'($urandom_range(0, 255));
               while (code == CH_BS || code == CH_TAB || code == CH_CR || code == CH_LF ||
                      (code >= CH_PRINT_LO && code <= CH_PRINT_HI));
            end else if (r < 975) begin
               kind  = KIND_READ;
               index = pick_read_index();
               code  = 8'($urandom_range(0, 255));
            end else if (r < 995) begin
               kind    = KIND_SPARE;
               ignored = 1'b1;
               code    = 8'($urandom_range(0, 255));
            end else begin
               kind = KIND_CLEAR;
               code = 8'($urandom_range(0, 255));
            end
            send_item(kind, code, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      index);
            if (!ignored) useful++;
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: text_console_cursor_scroll.f
+incdir+hw/rtl
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_ctrl.sv
hw/rtl/tccs_dp.sv
hw/rtl/text_console_cursor_scroll.sv
hw/rtl/tccs_checker.sv
test/text_console_cursor_scroll_checker.sv
test/text_console_cursor_scroll_tb.sv
